/* src/fkb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkb_pkg
// Shared constants, tables and types of the fisheye projection pipeline.
// ----------------------------------------------------------------------------
package fkb_pkg;

  // number of cordic vectoring stages and fraction bits of pixel values
  localparam int CORDIC_STAGES = 24;
  localparam int FRAC_BITS     = 16;

  // pipeline sizes
  localparam int SQRT_STAGES  = 32;
  localparam int DIV_STAGES   = 31;
  localparam int HORNER_STEPS = 4;

  // cordic vector width and angle width
  localparam int CW = 36;
  localparam int AW = 34;

  localparam logic signed [AW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [34:0]   ONE_Q30     = 35'sd1073741824;
  localparam logic [61:0]          SAT62       = '1;
  localparam logic signed [63:0]   SAT62_S     = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [31:0]   MINUS_ONE   = -(32'sd1 <<< FRAC_BITS);
  localparam logic [31:0]          FOCAL_RESET = 32'd1 << FRAC_BITS;

  // atan(2^-i) in q30
  localparam logic [29:0] ATAN_TABLE [32] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
    30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
    30'd127, 30'd63, 30'd31, 30'd15, 30'd7, 30'd3, 30'd1, 30'd0, 30'd0
  };

  // register map, word index
  typedef enum logic [2:0] {
    REG_FOCAL_X,
    REG_FOCAL_Y,
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_DIST_K1,
    REG_DIST_K2,
    REG_DIST_K3,
    REG_DIST_K4
  } reg_addr_e;

  // side data that rides along the arithmetic back end
  typedef struct packed {
    logic signed [AW-1:0] th;
    logic signed [34:0]   t2;
    logic signed [31:0]   ratio_x;
    logic signed [31:0]   ratio_y;
    logic                 rej;
    logic                 rz;
  } ride_t;

  // request into the ratio divider
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [31:0]        r;
    logic               rej;
    logic               rz;
  } div_in_t;

  // result of the ratio divider
  typedef struct packed {
    logic signed [31:0] ratio_x;
    logic signed [31:0] ratio_y;
    logic signed [31:0] z;
    logic [31:0]        r;
    logic               rej;
    logic               rz;
  } div_out_t;

endpackage

/* src/fkb_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkb_mul
// Two-stage q30 multiplier: round half away from zero, saturate to 62 bits.
// ----------------------------------------------------------------------------
module fkb_mul import fkb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [62:0] a_i,
  input  logic signed [34:0] b_i,
  input  ride_t              side_i,
  output logic               valid_o,
  output logic signed [62:0] res_o,
  output ride_t              side_o
);

  logic [61:0]        mag_a;
  logic [33:0]        mag_b;
  logic [64:0]        plo_d, phi_d, plo_q, phi_q;
  logic               neg_d, neg_q;
  ride_t              side1_q, side2_q;
  logic               valid1_q, valid2_q;
  logic [95:0]        sum;
  logic [65:0]        shf;
  logic [61:0]        lim;
  logic signed [62:0] res_d, res_q;

  // magnitudes and split partial products
  assign mag_a = a_i[62] ? 62'(-a_i) : a_i[61:0];
  assign mag_b = b_i[34] ? 34'(-b_i) : b_i[33:0];
  assign neg_d = a_i[62] ^ b_i[34];
  assign plo_d = 65'(mag_a[30:0]) * 65'(mag_b);
  assign phi_d = 65'(mag_a[61:31]) * 65'(mag_b);

  // combine, round, shift and limit
  assign sum   = 96'(plo_q) + {phi_q, 31'b0} + 96'(30'h2000_0000);
  assign shf   = sum[95:30];
  assign lim   = (shf > 66'(SAT62)) ? SAT62 : shf[61:0];
  assign res_d = neg_q ? -$signed({1'b0, lim}) : $signed({1'b0, lim});

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else if (en_i) begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      plo_q   <= plo_d;
      phi_q   <= phi_d;
      neg_q   <= neg_d;
      side1_q <= side_i;
      res_q   <= res_d;
      side2_q <= side1_q;
    end
  end

  assign valid_o = valid2_q;
  assign res_o   = res_q;
  assign side_o  = side2_q;

endmodule

/* src/fkb_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fkb_div
// Pipelined restoring divider forming x/r and y/r in q30, rounded.
// ----------------------------------------------------------------------------
module fkb_div import fkb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  div_in_t  in_i,
  output logic     valid_o,
  output div_out_t out_o
);

  typedef struct packed {
    logic [31:0]        rem_x;
    logic [30:0]        nq_x;
    logic               sx;
    logic [31:0]        rem_y;
    logic [30:0]        nq_y;
    logic               sy;
    logic [31:0]        r;
    logic signed [31:0] z;
    logic               rej;
    logic               rz;
  } dstage_t;

  dstage_t   st_q [DIV_STAGES+1];
  logic      v_q  [DIV_STAGES+1];
  dstage_t   setup;
  logic [31:0] mx, my;
  logic [61:0] nx, ny;

  // numerators |c| * 2^30 + r/2, upper part seeds the remainder
  always_comb begin
    mx          = in_i.x[31] ? 32'(-in_i.x) : in_i.x;
    my          = in_i.y[31] ? 32'(-in_i.y) : in_i.y;
    nx          = {mx, 30'b0} + 62'(in_i.r[31:1]);
    ny          = {my, 30'b0} + 62'(in_i.r[31:1]);
    setup.rem_x = {1'b0, nx[61:31]};
    setup.nq_x  = nx[30:0];
    setup.sx    = in_i.x[31];
    setup.rem_y = {1'b0, ny[61:31]};
    setup.nq_y  = ny[30:0];
    setup.sy    = in_i.y[31];
    setup.r     = in_i.r;
    setup.z     = in_i.z;
    setup.rej   = in_i.rej;
    setup.rz    = in_i.rz;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= setup;
    end
  end

  // one quotient bit per stage for each axis
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
    logic [32:0] tx, ty;
    logic        gx, gy;
    dstage_t     nxt;

    always_comb begin
      tx        = {st_q[k].rem_x, st_q[k].nq_x[30]};
      ty        = {st_q[k].rem_y, st_q[k].nq_y[30]};
      gx        = tx >= {1'b0, st_q[k].r};
      gy        = ty >= {1'b0, st_q[k].r};
      nxt       = st_q[k];
      nxt.rem_x = gx ? 32'(tx - {1'b0, st_q[k].r}) : tx[31:0];
      nxt.rem_y = gy ? 32'(ty - {1'b0, st_q[k].r}) : ty[31:0];
      nxt.nq_x  = {st_q[k].nq_x[29:0], gx};
      nxt.nq_y  = {st_q[k].nq_y[29:0], gy};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k+1] <= nxt;
      end
    end
  end

  // signed ratios
  always_comb begin
    out_o.ratio_x = st_q[DIV_STAGES].sx ? -$signed({1'b0, st_q[DIV_STAGES].nq_x})
                                        : $signed({1'b0, st_q[DIV_STAGES].nq_x});
    out_o.ratio_y = st_q[DIV_STAGES].sy ? -$signed({1'b0, st_q[DIV_STAGES].nq_y})
                                        : $signed({1'b0, st_q[DIV_STAGES].nq_y});
    out_o.z       = st_q[DIV_STAGES].z;
    out_o.r       = st_q[DIV_STAGES].r;
    out_o.rej     = st_q[DIV_STAGES].rej;
    out_o.rz      = st_q[DIV_STAGES].rz;
  end

  assign valid_o = v_q[DIV_STAGES];

endmodule

/* src/fisheye_kb_project.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fisheye_kb_project
// Four-coefficient fisheye projection of rays to pixel positions.
// ----------------------------------------------------------------------------
// A ray request enters on the s_axis channel: tdata carries ray_x, ray_y and
// ray_z (signed q16.16), tuser carries check_front. The pixel leaves on the
// m_axis channel: tdata carries pixel_u and pixel_v, tuser carries behind.
// Camera focal lengths, principal point and distortion coefficients are set
// through the apb port; the user must write them only while no ray is in
// flight, as the block does not enforce this. pready is always high. A ray
// passes the input register, the squared radius and its bit-serial root,
// the ratio divider, the cordic pre-rotation and stages, theta squared and
// the polynomial, and the scaling and output register.
// One ray is taken each cycle unless the output stalls; all stages advance
// together. The whole pipeline holds, and s_axis_tready drops, only while a
// finished pixel waits on a stalled receiver; nothing is lost or repeated.
// Reset empties the pipeline and restores focal lengths to 1.0, principal
// point and coefficients to zero.
// ----------------------------------------------------------------------------
module fisheye_kb_project import fkb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // ray request
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // ray_x, ray_y, ray_z
  input  logic        s_axis_tuser,   // check_front
  // pixel result
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // pixel_u, pixel_v
  output logic        m_axis_tuser,   // behind
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef struct packed {
    logic [63:0]        n;
    logic [63:0]        res;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               rej;
  } sstage_t;

  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [AW-1:0] acc;
    ride_t                ride;
  } cstage_t;

  logic adv;

  logic [31:0] focal_x_q, focal_y_q, center_x_q, center_y_q;
  logic [31:0] dist_k1_q, dist_k2_q, dist_k3_q, dist_k4_q;
  logic        wr_en;

  // configuration registers
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q  <= FOCAL_RESET;
      focal_y_q  <= FOCAL_RESET;
      center_x_q <= '0;
      center_y_q <= '0;
      dist_k1_q  <= '0;
      dist_k2_q  <= '0;
      dist_k3_q  <= '0;
      dist_k4_q  <= '0;
    end else if (wr_en) begin
      unique case (reg_addr_e'(paddr[4:2]))
        REG_FOCAL_X:  focal_x_q  <= pwdata;
        REG_FOCAL_Y:  focal_y_q  <= pwdata;
        REG_CENTER_X: center_x_q <= pwdata;
        REG_CENTER_Y: center_y_q <= pwdata;
        REG_DIST_K1:  dist_k1_q  <= pwdata;
        REG_DIST_K2:  dist_k2_q  <= pwdata;
        REG_DIST_K3:  dist_k3_q  <= pwdata;
        REG_DIST_K4:  dist_k4_q  <= pwdata;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_addr_e'(paddr[4:2]))
      REG_FOCAL_X:  prdata = focal_x_q;
      REG_FOCAL_Y:  prdata = focal_y_q;
      REG_CENTER_X: prdata = center_x_q;
      REG_CENTER_Y: prdata = center_y_q;
      REG_DIST_K1:  prdata = dist_k1_q;
      REG_DIST_K2:  prdata = dist_k2_q;
      REG_DIST_K3:  prdata = dist_k3_q;
      REG_DIST_K4:  prdata = dist_k4_q;
    endcase
  end

  // global advance: hold everything while a pixel waits
  logic out_valid_q;
  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;

  // input register and squares
  logic               f0_v_q, f1_v_q;
  logic signed [31:0] f0_x_q, f0_y_q, f0_z_q, f1_x_q, f1_y_q, f1_z_q;
  logic               f0_rej_q, f1_rej_q;
  logic [31:0]        mag_x, mag_y;
  logic [63:0]        sqx_q, sqy_q;

  assign mag_x = f0_x_q[31] ? 32'(-f0_x_q) : f0_x_q;
  assign mag_y = f0_y_q[31] ? 32'(-f0_y_q) : f0_y_q;

  sstage_t s_q [SQRT_STAGES+1];
  logic    sv_q [SQRT_STAGES+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f0_v_q <= 1'b0;
      f1_v_q <= 1'b0;
      sv_q[0] <= 1'b0;
    end else if (adv) begin
      f0_v_q  <= s_axis_tvalid;
      f1_v_q  <= f0_v_q;
      sv_q[0] <= f1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f0_x_q       <= s_axis_tdata[31:0];
      f0_y_q       <= s_axis_tdata[63:32];
      f0_z_q       <= s_axis_tdata[95:64];
      f0_rej_q     <= s_axis_tuser && ($signed(s_axis_tdata[95:64]) <= 32'sd0);
      sqx_q        <= 64'(mag_x) * 64'(mag_x);
      sqy_q        <= 64'(mag_y) * 64'(mag_y);
      f1_x_q       <= f0_x_q;
      f1_y_q       <= f0_y_q;
      f1_z_q       <= f0_z_q;
      f1_rej_q     <= f0_rej_q;
      s_q[0].n     <= sqx_q + sqy_q;
      s_q[0].res   <= '0;
      s_q[0].x     <= f1_x_q;
      s_q[0].y     <= f1_y_q;
      s_q[0].z     <= f1_z_q;
      s_q[0].rej   <= f1_rej_q;
    end
  end

  // bit-serial square root, one result bit per stage
  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
    logic [63:0] trial;
    sstage_t     nxt;

    always_comb begin
      trial = s_q[j].res + BIT;
      nxt   = s_q[j];
      if (s_q[j].n >= trial) begin
        nxt.n   = s_q[j].n - trial;
        nxt.res = (s_q[j].res >> 1) + BIT;
      end else begin
        nxt.res = s_q[j].res >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sv_q[j+1] <= 1'b0;
      end else if (adv) begin
        sv_q[j+1] <= sv_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        s_q[j+1] <= nxt;
      end
    end
  end

  // ratio divider
  div_in_t  div_in;
  div_out_t div_out;
  logic     div_v;

  always_comb begin
    div_in.x   = s_q[SQRT_STAGES].x;
    div_in.y   = s_q[SQRT_STAGES].y;
    div_in.z   = s_q[SQRT_STAGES].z;
    div_in.r   = s_q[SQRT_STAGES].res[31:0];
    div_in.rej = s_q[SQRT_STAGES].rej;
    div_in.rz  = (s_q[SQRT_STAGES].res[31:0] == 32'd0);
  end

  fkb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (sv_q[SQRT_STAGES]),
    .in_i    (div_in),
    .valid_o (div_v),
    .out_o   (div_out)
  );

  // cordic pre-rotation for rays behind the camera plane
  cstage_t c_q  [CORDIC_STAGES+1];
  logic    cv_q [CORDIC_STAGES+1];
  cstage_t pre;

  always_comb begin
    pre.ride.th      = '0;
    pre.ride.t2      = '0;
    pre.ride.ratio_x = div_out.ratio_x;
    pre.ride.ratio_y = div_out.ratio_y;
    pre.ride.rej     = div_out.rej;
    pre.ride.rz      = div_out.rz;
    if (div_out.z[31]) begin
      pre.cx  = $signed({{(CW-32){1'b0}}, div_out.r});
      pre.cy  = -CW'(div_out.z);
      pre.acc = HALF_PI_Q30;
    end else begin
      pre.cx  = CW'(div_out.z);
      pre.cy  = $signed({{(CW-32){1'b0}}, div_out.r});
      pre.acc = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q[0] <= 1'b0;
    end else if (adv) begin
      cv_q[0] <= div_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_q[0] <= pre;
    end
  end

  // cordic vectoring stages
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    localparam logic signed [AW-1:0] ANG = $signed({{(AW-30){1'b0}}, ATAN_TABLE[i]});
    cstage_t nxt;

    always_comb begin
      nxt = c_q[i];
      if (!c_q[i].cy[CW-1]) begin
        nxt.cx  = c_q[i].cx + (c_q[i].cy >>> i);
        nxt.cy  = c_q[i].cy - (c_q[i].cx >>> i);
        nxt.acc = c_q[i].acc + ANG;
      end else begin
        nxt.cx  = c_q[i].cx - (c_q[i].cy >>> i);
        nxt.cy  = c_q[i].cy + (c_q[i].cx >>> i);
        nxt.acc = c_q[i].acc - ANG;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[i+1] <= 1'b0;
      end else if (adv) begin
        cv_q[i+1] <= cv_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        c_q[i+1] <= nxt;
      end
    end
  end

  // theta squared
  ride_t              ride_c, t2_side, ride_t2;
  logic               t2_v;
  logic signed [62:0] t2_res;

  always_comb begin
    ride_c    = c_q[CORDIC_STAGES].ride;
    ride_c.th = c_q[CORDIC_STAGES].acc;
  end

  fkb_mul u_mul_t2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (cv_q[CORDIC_STAGES]),
    .a_i     (63'(c_q[CORDIC_STAGES].acc)),
    .b_i     (35'(c_q[CORDIC_STAGES].acc)),
    .side_i  (ride_c),
    .valid_o (t2_v),
    .res_o   (t2_res),
    .side_o  (t2_side)
  );

  always_comb begin
    ride_t2    = t2_side;
    ride_t2.t2 = 35'(t2_res);
  end

  // horner steps of the distortion polynomial
  logic signed [34:0] addend [HORNER_STEPS];
  logic signed [62:0] h_q    [HORNER_STEPS];
  ride_t              hride_q[HORNER_STEPS];
  logic               hv_q   [HORNER_STEPS];

  always_comb begin
    addend[0] = 35'($signed({dist_k3_q, 2'b00}));
    addend[1] = 35'($signed({dist_k2_q, 2'b00}));
    addend[2] = 35'($signed({dist_k1_q, 2'b00}));
    addend[3] = ONE_Q30;
  end

  for (genvar s = 0; s < HORNER_STEPS; s++) begin : g_horner
    logic signed [62:0] a_in;
    ride_t              side_in;
    logic               v_in;
    logic               m_v;
    logic signed [62:0] m_res;
    ride_t              m_side;
    logic signed [63:0] sum;
    logic signed [62:0] h_d;

    if (s == 0) begin : g_first
      assign a_in    = 63'($signed({dist_k4_q, 2'b00}));
      assign side_in = ride_t2;
      assign v_in    = t2_v;
    end else begin : g_next
      assign a_in    = h_q[s-1];
      assign side_in = hride_q[s-1];
      assign v_in    = hv_q[s-1];
    end

    fkb_mul u_mul (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (v_in),
      .a_i     (a_in),
      .b_i     (side_in.t2),
      .side_i  (side_in),
      .valid_o (m_v),
      .res_o   (m_res),
      .side_o  (m_side)
    );

    // add the coefficient and clamp to 62 bits
    always_comb begin
      sum = 64'(addend[s]) + 64'(m_res);
      if (sum > SAT62_S) begin
        h_d = 63'(SAT62_S);
      end else if (sum < -SAT62_S) begin
        h_d = 63'(-SAT62_S);
      end else begin
        h_d = 63'(sum);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        hv_q[s] <= 1'b0;
      end else if (adv) begin
        hv_q[s] <= m_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        h_q[s]     <= h_d;
        hride_q[s] <= m_side;
      end
    end
  end

  // distortion d = theta * h
  logic               d_v;
  logic signed [62:0] d_res;
  ride_t              d_side;

  fkb_mul u_mul_d (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (hv_q[HORNER_STEPS-1]),
    .a_i     (h_q[HORNER_STEPS-1]),
    .b_i     (35'(hride_q[HORNER_STEPS-1].th)),
    .side_i  (hride_q[HORNER_STEPS-1]),
    .valid_o (d_v),
    .res_o   (d_res),
    .side_o  (d_side)
  );

  // d times the direction ratios
  logic               px_v, py_v;
  logic signed [62:0] px_res, py_res;
  ride_t              px_side, py_side;

  fkb_mul u_mul_px (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (d_v),
    .a_i     (d_res),
    .b_i     (35'(d_side.ratio_x)),
    .side_i  (d_side),
    .valid_o (px_v),
    .res_o   (px_res),
    .side_o  (px_side)
  );

  fkb_mul u_mul_py (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (d_v),
    .a_i     (d_res),
    .b_i     (35'(d_side.ratio_y)),
    .side_i  (d_side),
    .valid_o (py_v),
    .res_o   (py_res),
    .side_o  (py_side)
  );

  // scale by the focal lengths
  logic               su_v, sv_v;
  logic signed [62:0] su_res, sv_res;
  ride_t              su_side, sv_side;

  fkb_mul u_mul_su (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (px_v),
    .a_i     (px_res),
    .b_i     ($signed({3'b000, focal_x_q})),
    .side_i  (px_side),
    .valid_o (su_v),
    .res_o   (su_res),
    .side_o  (su_side)
  );

  fkb_mul u_mul_sv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (py_v),
    .a_i     (py_res),
    .b_i     ($signed({3'b000, focal_y_q})),
    .side_i  (py_side),
    .valid_o (sv_v),
    .res_o   (sv_res),
    .side_o  (sv_side)
  );

  // saturate to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

  // add the principal point and pick rejected or on-axis cases
  logic signed [31:0] u_d, v_d, u_q, v_q;
  logic               behind_q;

  always_comb begin
    priority if (su_side.rej) begin
      u_d = MINUS_ONE;
    end else if (su_side.rz) begin
      u_d = sat32(64'($signed({1'b0, center_x_q})));
    end else begin
      u_d = sat32(64'(su_res) + 64'($signed({1'b0, center_x_q})));
    end
    priority if (sv_side.rej) begin
      v_d = MINUS_ONE;
    end else if (sv_side.rz) begin
      v_d = sat32(64'($signed({1'b0, center_y_q})));
    end else begin
      v_d = sat32(64'(sv_res) + 64'($signed({1'b0, center_y_q})));
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= su_v & sv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      u_q      <= u_d;
      v_q      <= v_d;
      behind_q <= su_side.rej;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {v_q, u_q};
  assign m_axis_tuser  = behind_q;

endmodule

/* tb/sv/fisheye_kb_project_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fisheye_kb_project_test
// Self-checking bench for the fisheye ray-to-pixel projection pipeline.
// Rays go in on the stream input and pixels come back on the stream output.
// A bit-exact software copy of the projection turns each accepted ray into
// the pixel it should give. Pixels are checked in order. Camera settings
// are written over apb between phases, with the extremes among them. Both
// stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module fisheye_kb_project_test import fkb_pkg::*;;

  localparam int  LIMIT_CYCLES = 400000;
  localparam int  DRAIN_CYCLES = 150;
  localparam int  RAND_RAYS    = 640;
  localparam longint SAT_MAG   = 64'sh3FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [31:0] u;
    logic [31:0] v;
    logic        behind;
  } pixel_t;

  // projection predictor and store of pixels still due
  class pixel_board;
    logic [31:0] focal[2];
    logic [31:0] center[2];
    logic [31:0] kcoef[4];
    pixel_t      due_pixels[$];
    int          mismatches;

    function new();
      focal[0] = FOCAL_RESET;
      focal[1] = FOCAL_RESET;
      center[0] = '0;
      center[1] = '0;
      foreach (kcoef[i]) kcoef[i] = '0;
      mismatches = 0;
    endfunction

    function void set_reg(reg_addr_e idx, logic [31:0] val);
      case (idx)
        REG_FOCAL_X:  focal[0] = val;
        REG_FOCAL_Y:  focal[1] = val;
        REG_CENTER_X: center[0] = val;
        REG_CENTER_Y: center[1] = val;
        REG_DIST_K1:  kcoef[0] = val;
        REG_DIST_K2:  kcoef[1] = val;
        REG_DIST_K3:  kcoef[2] = val;
        default:      kcoef[3] = val;
      endcase
    endfunction

    function longint unsigned magn(longint v);
      return v < 0 ? longint'(-v) : v;
    endfunction

    // product scaled down by 2^sh, rounded half away from zero, saturated
    function longint scaled_mul(longint a, longint b, int sh);
      logic [127:0] p;
      longint res;
      p = {64'd0, magn(a)} * {64'd0, magn(b)};
      p = (p + (128'd1 << (sh - 1))) >> sh;
      res = (p > 128'(SAT_MAG)) ? SAT_MAG : longint'(p[63:0]);
      return ((a < 0) != (b < 0)) ? -res : res;
    endfunction

    function longint clamp_sat(longint v);
      if (v > SAT_MAG) return SAT_MAG;
      if (v < -SAT_MAG) return -SAT_MAG;
      return v;
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint unsigned int_root(longint unsigned n);
      longint unsigned res, bt;
      res = 0;
      bt = 64'd1 << 62;
      while (bt > n) bt >>= 2;
      while (bt != 0) begin
        if (n >= res + bt) begin
          n -= res + bt;
          res = (res >> 1) + bt;
        end else begin
          res >>= 1;
        end
        bt >>= 2;
      end
      return res;
    endfunction

    // vectoring angle of (xv, yv) in q30, yv never negative
    function longint ray_angle(longint yv, longint xv);
      longint ax, ay, acc, dx, dy;
      ax = xv;
      ay = yv;
      acc = 0;
      if (xv < 0) begin
        ax = yv;
        ay = -xv;
        acc = HALF_PI_Q30;
      end
      for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
        dx = ay >>> i;
        dy = ax >>> i;
        if (ay >= 0) begin
          ax += dx; ay -= dy; acc += longint'(ATAN_TABLE[i]);
        end else begin
          ax -= dx; ay += dy; acc -= longint'(ATAN_TABLE[i]);
        end
      end
      return acc;
    endfunction

    function logic [31:0] axis_pixel(longint c, longint unsigned r, longint d, int ax);
      longint unsigned q;
      longint ratio, p, s;
      q = ((magn(c) << 30) + (r >> 1)) / r;
      ratio = c < 0 ? -longint'(q) : longint'(q);
      p = scaled_mul(d, ratio, 30);
      s = scaled_mul(p, longint'({32'd0, focal[ax]}), 30);
      s = clamp32(s + longint'({32'd0, center[ax]}));
      return s[31:0];
    endfunction

    // work out the pixel an accepted ray must give
    function void note_ray(logic [95:0] ray, logic chk);
      longint x, y, z, th, t2, h, d;
      longint unsigned r;
      pixel_t px;
      x = longint'($signed(ray[31:0]));
      y = longint'($signed(ray[63:32]));
      z = longint'($signed(ray[95:64]));
      px.behind = 1'b0;
      if (chk && z <= 0) begin
        px.u = MINUS_ONE;
        px.v = MINUS_ONE;
        px.behind = 1'b1;
      end else begin
        r = int_root(magn(x) * magn(x) + magn(y) * magn(y));
        if (r == 0) begin
          px.u = 32'(clamp32(longint'({32'd0, center[0]})));
          px.v = 32'(clamp32(longint'({32'd0, center[1]})));
        end else begin
          th = ray_angle(longint'(r), z);
          t2 = scaled_mul(th, th, 30);
          h = longint'($signed(kcoef[3])) * 4;
          for (int k = 2; k >= 0; k--)
            h = clamp_sat(longint'($signed(kcoef[k])) * 4 + scaled_mul(t2, h, 30));
          h = clamp_sat(longint'(ONE_Q30) + scaled_mul(t2, h, 30));
          d = scaled_mul(th, h, 30);
          px.u = axis_pixel(x, r, d, 0);
          px.v = axis_pixel(y, r, d, 1);
        end
      end
      due_pixels.push_back(px);
    endfunction

    // compare one delivered pixel with the oldest one due
    function void check_pixel(logic [31:0] u, logic [31:0] v, logic behind);
      pixel_t px;
      if (due_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pixel u=%h v=%h behind=%b", u, v, behind);
        return;
      end
      px = due_pixels.pop_front();
      if (u !== px.u || v !== px.v || behind !== px.behind) begin
        mismatches++;
        if (mismatches <= 10)
          $display("pixel mismatch: exp u=%h v=%h behind=%b got u=%h v=%h behind=%b",
                   px.u, px.v, px.behind, u, v, behind);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;   // ray_x, ray_y, ray_z
  logic        s_axis_tuser = 1'b0; // check_front
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // pixel_u, pixel_v
  logic        m_axis_tuser;        // behind
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pixel_board board = new();
  int send_idle = 0;
  int recv_idle = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_cnt = 0;
  int cycles = 0;

  fisheye_kb_project i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #2 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("fisheye_kb_project test failed");
      $finish;
    end
  end

  // pixel receiver with random stalls and requested long hold-offs
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready)
      board.check_pixel(m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser);
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_ray(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic chk);
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {z, y, x};
    s_axis_tuser <= chk;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_ray({z, y, x}, chk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (board.due_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_addr_e idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(idx) << 2;
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    board.set_reg(idx, val);
  endtask

  function automatic logic [31:0] coord(int span);
    logic [31:0] c;
    c = $urandom_range(0, (1 << span) - 1);
    return $urandom_range(1) ? -c : c;
  endfunction

  // random rays: mostly camera-like, some full range, some on the axis
  task automatic random_rays(int n);
    logic [31:0] x, y, z;
    int kind;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(99);
      if (kind < 60) begin
        x = coord($urandom_range(4, 22));
        y = coord($urandom_range(4, 22));
        z = ($urandom_range(9) == 0) ? coord(20) : $urandom_range(1, 1 << 20);
      end else if (kind < 90) begin
        x = $urandom;
        y = $urandom;
        z = $urandom;
      end else begin
        x = '0;
        y = '0;
        z = $urandom;
      end
      send_ray(x, y, z, $urandom_range(1));
      if (i == 100) hold_req <= hold_req + 1;
      if (i == 300) wait_drained();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rays at reset settings
    send_idle = 37;
    recv_idle = 53;
    send_ray(32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 1'b1);
    send_ray(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 1'b0);
    send_ray(32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 1'b0);
    send_ray(32'h0001_0000, 32'h0002_0000, 32'h0000_0000, 1'b1);
    send_ray(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 1'b1);
    send_ray(32'h0001_0000, 32'h0002_0000, 32'h8000_0000, 1'b0);
    send_ray(32'h0001_0000, 32'hFFFE_0000, 32'h0000_0000, 1'b0);
    send_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    send_ray(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    send_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    send_ray(32'h0000_0001, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1);
    send_ray(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001, 1'b1);
    send_ray(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
    wait_drained();

    // extreme settings with directed rays
    write_reg(REG_FOCAL_X, 32'hFFFF_FFFF);
    write_reg(REG_FOCAL_Y, 32'h0000_0000);
    write_reg(REG_CENTER_X, 32'hFFFF_FFFF);
    write_reg(REG_CENTER_Y, 32'h8000_0000);
    write_reg(REG_DIST_K1, 32'h7FFF_FFFF);
    write_reg(REG_DIST_K2, 32'h8000_0000);
    write_reg(REG_DIST_K3, 32'h7FFF_FFFF);
    write_reg(REG_DIST_K4, 32'h8000_0000);
    send_ray(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 1'b1);
    send_ray(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, 1'b1);
    send_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_ray(32'h0000_0100, 32'h0000_0100, 32'h7FFF_0000, 1'b0);
    send_ray(32'h0010_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
    random_rays(60);
    wait_drained();

    // camera-like settings
    write_reg(REG_FOCAL_X, 32'd300 << 16);
    write_reg(REG_FOCAL_Y, 32'd298 << 16);
    write_reg(REG_CENTER_X, 32'd640 << 16);
    write_reg(REG_CENTER_Y, 32'd360 << 16);
    write_reg(REG_DIST_K1, -32'sd2684354);
    write_reg(REG_DIST_K2, 32'sd1342177);
    write_reg(REG_DIST_K3, -32'sd268435);
    write_reg(REG_DIST_K4, 32'sd26843);
    random_rays(RAND_RAYS);
    wait_drained();

    // random settings, roles of the two sides swapped
    send_idle = 53;
    recv_idle = 37;
    write_reg(REG_FOCAL_X, $urandom);
    write_reg(REG_FOCAL_Y, $urandom);
    write_reg(REG_CENTER_X, $urandom);
    write_reg(REG_CENTER_Y, $urandom);
    write_reg(REG_DIST_K1, $urandom);
    write_reg(REG_DIST_K2, $urandom);
    write_reg(REG_DIST_K3, $urandom);
    write_reg(REG_DIST_K4, $urandom);
    random_rays(RAND_RAYS);
    wait_drained();

    // moderate random settings, no idling
    send_idle = 0;
    recv_idle = 0;
    write_reg(REG_FOCAL_X, $urandom_range(0, 32'h03FF_FFFF));
    write_reg(REG_FOCAL_Y, $urandom_range(0, 32'h03FF_FFFF));
    write_reg(REG_CENTER_X, $urandom_range(0, 32'h07FF_FFFF));
    write_reg(REG_CENTER_Y, $urandom_range(0, 32'h07FF_FFFF));
    write_reg(REG_DIST_K1, $urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000);
    write_reg(REG_DIST_K2, $urandom_range(0, 32'h03FF_FFFF) - 32'h0200_0000);
    write_reg(REG_DIST_K3, $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000);
    write_reg(REG_DIST_K4, $urandom_range(0, 32'h003F_FFFF) - 32'h0020_0000);
    random_rays(RAND_RAYS);
    wait_drained();

    if (board.mismatches == 0) begin
      $display("fisheye_kb_project test passed");
    end else begin
      $display("fisheye_kb_project test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
src/fkb_pkg.sv
src/fkb_mul.sv
src/fkb_div.sv
src/fisheye_kb_project.sv
tb/sv/fisheye_kb_project_test.sv
